[hw/rtl/fcw_pkg.sv]
// shared types and constants for the form chunk walker
`default_nettype none

package fcw_pkg;

  // configuration register indexes
  localparam logic CFG_TARGET_TAG = 1'b0;
  localparam logic CFG_TARGET_OCC = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_CHUNK     = 2'd0;
  localparam logic [1:0] KIND_FORM_END  = 2'd1;
  localparam logic [1:0] KIND_EARLY_END = 2'd2;

  // file layout constants
  localparam logic [31:0] TAG_PAD     = 32'h5041_4420;
  localparam int unsigned FIRST_CHUNK = 12;
  localparam int unsigned HDR_LEN     = 8;
  localparam int unsigned SIZE_OFS    = 7;
  localparam int unsigned TYPE_OFS    = 11;
  localparam int unsigned TAG_REL     = 3;
  localparam int unsigned SIZE_REL    = 7;

  // width of the packed result data word
  localparam int unsigned TDATA_W = 136;

  // walk phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_CHUNKS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  // one result as held in the output queue
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag;
    logic [31:0] size;
    logic [31:0] body;
    logic        is_target;
    logic        found;
    logic [31:0] form_type;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/form_chunk_walker.sv]
// form chunk walker: byte-serial parser of a FORM-style chunk file
`default_nettype none

// Takes one byte of the file per cycle (s_tuser marks offset zero and restarts the walk,
// s_tlast marks the last byte the source sends) and reports every chunk whose tag is not
// 'PAD ', plus one end result: end of form, or stream ended early. A byte is parsed in the
// cycle it is accepted and its results sit in a four-entry output queue on the next cycle.
// A byte can produce up to two results, and s_tready is low whenever the queue has fewer than
// two free entries, so the sustained rate is one byte per cycle while the result side keeps up.
// Make configuration writes only while no byte is in work; the block itself does not check.
module form_chunk_walker #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [31:0]                 cfg_data,
  // byte stream in
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,  // [7:0] data_byte
  input  wire logic                        s_tuser,  // [0] first_byte
  input  wire logic                        s_tlast,  // stream_end
  // results out
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [31:0] chunk_tag, [63:32] chunk_size, [95:64] body_offset, [96] is_target,
  // [97] target_found, [129:98] form_type, [135:130] zero
  output logic [fcw_pkg::TDATA_W-1:0]      m_tdata,
  output logic [1:0]                       m_tuser,  // [1:0] result_kind
  output logic                             m_tlast   // run_last
);

  import fcw_pkg::*;

  localparam int unsigned OB = OFFSET_BITS;
  localparam logic [OB-1:0] OFS_MAX = {OB{1'b1}};

  // saturate a sum to the offset range
  function automatic logic [OB-1:0] sat_ofs(input logic [32:0] v);
    logic [32:0] lim;
    lim = {{(33 - OB){1'b0}}, OFS_MAX};
    if (v > lim) begin
      return OFS_MAX;
    end
    return v[OB-1:0];
  endfunction

  // configuration registers
  logic [31:0] target_tag;
  logic [15:0] target_occ;

  // walk state
  logic [OB-1:0] byte_offset, byte_offset_next;
  logic [31:0]   word_shift, word_shift_next;
  logic [OB-1:0] form_end, form_end_next;
  logic [31:0]   form_kind, form_kind_next;
  logic [31:0]   cur_tag, cur_tag_next;
  logic [OB-1:0] next_chunk_at, next_chunk_at_next;
  phase_t        phase, phase_next;
  logic [15:0]   match_count, match_count_next;
  logic          found_flag, found_flag_next;

  // output queue
  result_t     queue [4];
  logic [1:0]  rd_ptr, wr_ptr;
  logic [2:0]  count, count_next;

  logic in_acc, out_acc;

  // state as seen by the current byte (restart applied)
  logic [OB-1:0] o_e, form_end_e, nca_e;
  logic [31:0]   ws_e, form_kind_e, cur_tag_e;
  phase_t        phase_e;
  logic [15:0]   match_e;
  logic          found_e;

  // chunk header decode
  logic          at_chunk;
  logic [OB-1:0] rel;
  logic [OB-1:0] body;
  logic [OB-1:0] nca_after;
  logic          chunk_res, end_res, early_res, hit;

  result_t res_a, res_b;
  logic    push_a, push_b;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;
  assign s_tready = (count <= 3'd2);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_tag <= '0;
      target_occ <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_TAG: target_tag <= cfg_data;
        CFG_TARGET_OCC: target_occ <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // effective state: first byte restarts the walk
  always_comb begin
    if (s_tuser) begin
      o_e         = '0;
      ws_e        = {24'd0, s_tdata};
      form_end_e  = '0;
      form_kind_e = '0;
      cur_tag_e   = '0;
      nca_e       = OB'(FIRST_CHUNK);
      phase_e     = PH_HEADER;
      match_e     = '0;
      found_e     = 1'b0;
    end else begin
      o_e         = byte_offset;
      ws_e        = {word_shift[23:0], s_tdata};
      form_end_e  = form_end;
      form_kind_e = form_kind;
      cur_tag_e   = cur_tag;
      nca_e       = next_chunk_at;
      phase_e     = phase;
      match_e     = match_count;
      found_e     = found_flag;
    end
  end

  // chunk header arithmetic
  assign at_chunk  = (phase_e == PH_CHUNKS) && (o_e >= nca_e);
  assign rel       = o_e - nca_e;
  assign body      = sat_ofs({{(33 - OB){1'b0}}, nca_e} + 33'(HDR_LEN));
  assign nca_after = sat_ofs({{(33 - OB){1'b0}}, body} + {1'b0, ws_e});

  // per-byte parse step
  always_comb begin
    byte_offset_next   = byte_offset;
    word_shift_next    = word_shift;
    form_end_next      = form_end;
    form_kind_next     = form_kind;
    cur_tag_next       = cur_tag;
    next_chunk_at_next = next_chunk_at;
    phase_next         = phase;
    match_count_next   = match_count;
    found_flag_next    = found_flag;
    chunk_res          = 1'b0;
    end_res            = 1'b0;
    early_res          = 1'b0;
    hit                = 1'b0;
    if (in_acc) begin
      word_shift_next    = ws_e;
      form_end_next      = form_end_e;
      form_kind_next     = form_kind_e;
      cur_tag_next       = cur_tag_e;
      next_chunk_at_next = nca_e;
      phase_next         = phase_e;
      match_count_next   = match_e;
      found_flag_next    = found_e;
      if (phase_e == PH_HEADER) begin
        if (o_e == OB'(SIZE_OFS)) begin
          form_end_next = sat_ofs({1'b0, ws_e} + 33'(HDR_LEN));
        end
        if (o_e == OB'(TYPE_OFS)) begin
          form_kind_next     = ws_e;
          next_chunk_at_next = OB'(FIRST_CHUNK);
          phase_next         = PH_CHUNKS;
          if ((OB + 1)'(FIRST_CHUNK + HDR_LEN) > {1'b0, form_end_e}) begin
            end_res    = 1'b1;
            phase_next = PH_DONE;
          end
        end
      end else if (at_chunk) begin
        if (rel == OB'(TAG_REL)) begin
          cur_tag_next = ws_e;
        end else if (rel == OB'(SIZE_REL)) begin
          if (cur_tag_e != TAG_PAD) begin
            chunk_res = 1'b1;
            if (cur_tag_e == target_tag) begin
              if (!found_e && match_e == target_occ) begin
                hit             = 1'b1;
                found_flag_next = 1'b1;
              end
              if (match_e != 16'hFFFF) begin
                match_count_next = match_e + 16'd1;
              end
            end
          end
          next_chunk_at_next = nca_after;
          if ({1'b0, nca_after} + (OB + 1)'(HDR_LEN) > {1'b0, form_end_e}) begin
            end_res    = 1'b1;
            phase_next = PH_DONE;
          end
        end
      end
      // stream ended before the form did
      if (s_tlast && !end_res && phase_e != PH_DONE) begin
        early_res  = 1'b1;
        phase_next = PH_DONE;
      end
      byte_offset_next = (o_e != OFS_MAX) ? o_e + OB'(1) : o_e;
    end
  end

  // assemble up to two results for this byte
  always_comb begin
    result_t chunk_r, end_r;
    chunk_r           = '0;
    chunk_r.kind      = KIND_CHUNK;
    chunk_r.tag       = cur_tag_e;
    chunk_r.size      = ws_e;
    chunk_r.body      = 32'(body);
    chunk_r.is_target = hit;
    chunk_r.form_type = form_kind_next;
    end_r             = '0;
    end_r.kind        = end_res ? KIND_FORM_END : KIND_EARLY_END;
    end_r.found       = found_flag_next;
    end_r.form_type   = form_kind_next;
    end_r.last        = 1'b1;
    if (chunk_res) begin
      res_a      = chunk_r;
      res_a.last = !(end_res || early_res);
      res_b      = end_r;
      push_a     = 1'b1;
      push_b     = end_res || early_res;
    end else begin
      res_a  = end_r;
      res_b  = end_r;
      push_a = end_res || early_res;
      push_b = 1'b0;
    end
  end

  // queue occupancy
  always_comb begin
    count_next = count + {2'd0, push_a} + {2'd0, push_b} - {2'd0, out_acc};
  end

  // walk state and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      word_shift    <= '0;
      form_end      <= '0;
      form_kind     <= '0;
      cur_tag       <= '0;
      next_chunk_at <= OB'(FIRST_CHUNK);
      phase         <= PH_HEADER;
      match_count   <= '0;
      found_flag    <= 1'b0;
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      count         <= '0;
    end else begin
      byte_offset   <= byte_offset_next;
      word_shift    <= word_shift_next;
      form_end      <= form_end_next;
      form_kind     <= form_kind_next;
      cur_tag       <= cur_tag_next;
      next_chunk_at <= next_chunk_at_next;
      phase         <= phase_next;
      match_count   <= match_count_next;
      found_flag    <= found_flag_next;
      wr_ptr        <= wr_ptr + {1'b0, push_a} + {1'b0, push_b};
      rd_ptr        <= rd_ptr + {1'b0, out_acc};
      count         <= count_next;
    end
  end

  // queue entries
  always_ff @(posedge clk) begin
    if (push_a) begin
      queue[wr_ptr] <= res_a;
    end
    if (push_b) begin
      queue[wr_ptr + 2'd1] <= res_b;
    end
  end

  // result port
  always_comb begin
    result_t head;
    head     = queue[rd_ptr];
    m_tvalid = (count != 3'd0);
    m_tuser  = head.kind;
    m_tlast  = head.last;
    m_tdata  = {6'd0, head.form_type, head.found, head.is_target,
                head.body, head.size, head.tag};
  end

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("output queue overflow");

  // a byte taken after the walk ended adds no result
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && !s_tuser && phase == PH_DONE) |=> count <= $past(count))
    else $error("result produced after end of walk");

  // found flag is only cleared by a restart
  assert property (@(posedge clk) disable iff (rst)
    (found_flag && !(in_acc && s_tuser)) |=> found_flag)
    else $error("found flag dropped without restart");

  // a first byte puts the walk at offset one
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tuser) |=> (byte_offset == OB'(1)))
    else $error("restart did not reset offset");

endmodule

`default_nettype wire
